FILE: design/prht_pkg.sv
package prht_pkg;

  localparam int ID_W      = 64;
  localparam int IN_PAY_W  = 32;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 8;
  localparam int RD_PAY_W  = 32;
  localparam int LCOUNT_W  = 9;
  localparam int LIMIT_W   = 7;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_OTHER  = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_LOAD      = 3'd3,
    ST_NO_SLOT   = 3'd4,
    ST_REMOVED   = 3'd5,
    ST_BAD_ID    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_REMOVE
  } action_t;

  localparam logic [63:0] HASH_MUL1      = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HASH_MUL2      = 64'hc4ceb9fe1a85ec53;
  localparam logic [31:0] HASH_SMALL_MUL = 32'd2654435761;
  localparam logic [63:0] SMALL_ID_LIMIT = 64'd1000;
  localparam int          HASH_SHIFT     = 33;
  localparam logic [6:0]  PERCENT        = 7'd100;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd70;

endpackage

FILE: design/prht_ram.sv
module prht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/pending_request_hash_table.sv
// Channel | Dir | Ports                          | Word
// in      | in  | in_tvalid/in_tready            | tdata id+payload, tuser req_type
// out     | out | out_tvalid/out_tready          | tdata status..live_count
// cfg     | in  | cfg_wr_en, cfg_wr_data         | load limit percentage
//
// One word is taken at a time. The hash takes one multiply for small ids and the two
// 64-bit multiplies on the shared 32x32 multiplier otherwise; each probe is a key memory
// read, then a compare; a slot-by-slot full scan may follow, and then the answer is given.
// After reset the key memory is cleared slot by slot before a word is accepted.
// A waiting result does not block acceptance; the next answer holds until out is free.
module pending_request_hash_table
  import prht_pkg::*;
#(
  parameter int TABLE_DEPTH  = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [95:0]         in_tdata,   // request_id[63:0], payload[95:64]
  input  logic [1:0]          in_tuser,   // req_type[1:0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [55:0]         out_tdata,  // status[2:0], slot[10:3], entry_live[11],
                                          // read_payload[43:12], live_count[52:44]
  input  logic                cfg_wr_en,
  input  logic [LIMIT_W-1:0]  cfg_wr_data
);

  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PROBE_LIMIT = (TABLE_DEPTH < 1024) ? TABLE_DEPTH : 16;
  localparam int PN_W        = $clog2(PROBE_LIMIT);
  localparam int LOAD_W      = CNT_W + 7;
  localparam int KEY_W       = ID_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_RD, S_CHK, S_SRD, S_SCHK, S_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [1:0]          type_r, type_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [IN_PAY_W-1:0] pay_r, pay_nxt;
  logic [63:0]         x_r, x_nxt, acc_r, acc_nxt, prod_r, prod_nxt;
  logic [1:0]          ph_r, ph_nxt;
  logic                rnd_r, rnd_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt, dist_r, dist_nxt, tomb_r, tomb_nxt;
  logic                have_tomb_r, have_tomb_nxt;
  logic [PN_W-1:0]     n_r, n_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_slot_r, res_slot_nxt;
  logic                res_live_r, res_live_nxt;
  logic [RD_PAY_W-1:0] res_pay_r, res_pay_nxt;
  action_t             act_r, act_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [55:0]         out_data_r, out_data_nxt;

  logic                  key_we;
  logic [IDX_W-1:0]      key_waddr;
  logic [KEY_W-1:0]      key_wdata, key_rdata;
  logic                  pay_we;
  logic [PAYLOAD_BITS-1:0] pay_rdata;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p, mul_c, hsum, hmix, in_id, in_mix;
  logic [41:0]  small_p;
  logic [LOAD_W-1:0] load_v;
  logic         key_hit, key_empty, key_live, last_probe, out_free, tomb_now;
  logic [IDX_W-1:0] tomb_sel;

  prht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (idx_r),
    .rdata (key_rdata)
  );

  prht_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(TABLE_DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (res_slot_r),
    .wdata (PAYLOAD_BITS'(pay_r)),
    .raddr (idx_r),
    .rdata (pay_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign in_id   = in_tdata[63:0];
  assign in_mix  = in_id ^ (in_id >> HASH_SHIFT);
  assign small_p = 42'(in_id[9:0]) * 42'(HASH_SMALL_MUL);
  assign load_v  = LOAD_W'((LOAD_W'(count_r) + 1'b1) * PERCENT) >> IDX_W;

  assign mul_c = rnd_r ? HASH_MUL2 : HASH_MUL1;
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign hsum  = {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
  assign hmix  = hsum ^ (hsum >> HASH_SHIFT);

  assign key_hit    = (key_rdata[ID_W-1:0] == id_r);
  assign key_empty  = (key_rdata[ID_W-1:0] == '0);
  assign key_live   = key_rdata[ID_W];
  assign last_probe = (n_r == PN_W'(PROBE_LIMIT - 1));
  assign tomb_now   = have_tomb_r || !key_live;
  assign tomb_sel   = have_tomb_r ? tomb_r : idx_r;

  always_comb begin
    mul_a = x_r[31:0];
    mul_b = mul_c[31:0];
    case (ph_r)
      2'd1:    mul_b = mul_c[63:32];
      2'd2:    mul_a = x_r[63:32];
      default: ;
    endcase
  end

  always_comb begin
    key_we    = 1'b0;
    key_waddr = res_slot_r;
    key_wdata = {1'b0, id_r};
    pay_we    = 1'b0;
    if (state_r == S_CLEAR) begin
      key_we    = 1'b1;
      key_waddr = clr_r;
      key_wdata = '0;
    end else if (state_r == S_RESP && out_free) begin
      if (act_r == ACT_INSERT) begin
        key_we    = 1'b1;
        key_wdata = {1'b1, id_r};
        pay_we    = 1'b1;
      end else if (act_r == ACT_REMOVE) begin
        key_we    = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    limit_nxt      = cfg_wr_en ? cfg_wr_data : limit_r;
    count_nxt      = count_r;
    type_nxt       = type_r;
    id_nxt         = id_r;
    pay_nxt        = pay_r;
    x_nxt          = x_r;
    acc_nxt        = acc_r;
    prod_nxt       = prod_r;
    ph_nxt         = ph_r;
    rnd_nxt        = rnd_r;
    idx_nxt        = idx_r;
    dist_nxt       = dist_r;
    tomb_nxt       = tomb_r;
    have_tomb_nxt  = have_tomb_r;
    n_nxt          = n_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_live_nxt   = res_live_r;
    res_pay_nxt    = res_pay_r;
    act_nxt        = act_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          type_nxt       = in_tuser;
          id_nxt         = in_id;
          pay_nxt        = in_tdata[95:64];
          res_status_nxt = ST_OK;
          res_slot_nxt   = '0;
          res_live_nxt   = 1'b0;
          res_pay_nxt    = '0;
          act_nxt        = ACT_NONE;
          dist_nxt       = IDX_W'(1);
          n_nxt          = '0;
          have_tomb_nxt  = 1'b0;
          ph_nxt         = 2'd0;
          rnd_nxt        = 1'b0;
          x_nxt          = in_mix;
          idx_nxt        = small_p[IDX_W-1:0];
          if (in_id == '0) begin
            res_status_nxt = ST_BAD_ID;
            state_nxt      = S_RESP;
          end else if (in_tuser == REQ_INSERT && load_v >= LOAD_W'(limit_r)) begin
            res_status_nxt = ST_LOAD;
            state_nxt      = S_RESP;
          end else if (in_id < SMALL_ID_LIMIT) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        // Low 64 bits of x*c from three 32x32 partial products.
        ph_nxt   = ph_r + 1'b1;
        prod_nxt = mul_p;
        case (ph_r)
          2'd1:    acc_nxt = prod_r;
          2'd2:    acc_nxt = hsum;
          2'd3: begin
            if (!rnd_r) begin
              x_nxt   = hmix;
              rnd_nxt = 1'b1;
            end else begin
              idx_nxt   = hmix[IDX_W-1:0];
              state_nxt = S_RD;
            end
          end
          default: ;
        endcase
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_RD;
        if (key_hit) begin
          res_slot_nxt = idx_r;
          state_nxt    = S_RESP;
          if (type_r == REQ_INSERT) begin
            res_status_nxt = ST_DUPLICATE;
          end else if (type_r == REQ_REMOVE) begin
            if (key_live) begin
              act_nxt = ACT_REMOVE;
            end else begin
              res_status_nxt = ST_REMOVED;
            end
          end else begin
            res_live_nxt = key_live;
            res_pay_nxt  = RD_PAY_W'(pay_rdata);
          end
        end else if (key_empty) begin
          state_nxt = S_RESP;
          if (type_r == REQ_INSERT) begin
            res_slot_nxt = tomb_sel;
            act_nxt      = ACT_INSERT;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
          end
        end else begin
          if (!have_tomb_r && !key_live) begin
            have_tomb_nxt = 1'b1;
            tomb_nxt      = idx_r;
          end
          if (last_probe) begin
            if (type_r == REQ_INSERT) begin
              state_nxt = S_RESP;
              if (tomb_now) begin
                res_slot_nxt = tomb_sel;
                act_nxt      = ACT_INSERT;
              end else begin
                res_status_nxt = ST_NO_SLOT;
              end
            end else begin
              idx_nxt   = '0;
              state_nxt = S_SRD;
            end
          end else begin
            dist_nxt = dist_r + 1'b1;
            idx_nxt  = idx_r + dist_r + 1'b1;
            n_nxt    = n_r + 1'b1;
          end
        end
      end
      S_SRD: begin
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (key_hit) begin
          res_slot_nxt = idx_r;
          state_nxt    = S_RESP;
          if (type_r == REQ_REMOVE) begin
            if (key_live) begin
              act_nxt = ACT_REMOVE;
            end else begin
              res_status_nxt = ST_REMOVED;
            end
          end else begin
            res_live_nxt = key_live;
            res_pay_nxt  = RD_PAY_W'(pay_rdata);
          end
        end else if (idx_r == IDX_W'(TABLE_DEPTH - 1)) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          if (act_r == ACT_INSERT) begin
            count_nxt = count_r + 1'b1;
          end else if (act_r == ACT_REMOVE && count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, LCOUNT_W'(count_nxt), res_pay_r, res_live_r,
                           SLOT_W'(res_slot_r), res_status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      limit_r     <= LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      limit_r     <= limit_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    type_r       <= type_nxt;
    id_r         <= id_nxt;
    pay_r        <= pay_nxt;
    x_r          <= x_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= prod_nxt;
    ph_r         <= ph_nxt;
    rnd_r        <= rnd_nxt;
    idx_r        <= idx_nxt;
    dist_r       <= dist_nxt;
    tomb_r       <= tomb_nxt;
    have_tomb_r  <= have_tomb_nxt;
    n_r          <= n_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_live_r   <= res_live_nxt;
    res_pay_r    <= res_pay_nxt;
    act_r        <= act_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
